// File: rtl/core/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, skipped while reset is held low.
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/swt_pkg.sv
`default_nettype none

package swt_pkg;

    // Characters that steer quoting and word splitting
    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_DQUOTE  = 8'h22;
    localparam logic [7:0] CH_SQUOTE  = 8'h27;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_DOLLAR  = 8'h24;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_PIPE    = 8'h7C;
    localparam logic [7:0] CH_LT      = 8'h3C;
    localparam logic [7:0] CH_GT      = 8'h3E;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_TWO     = 8'h32;

    // Reasons a word ends
    localparam logic [2:0] STOP_SPACE = 3'd0;
    localparam logic [2:0] STOP_END   = 3'd1;
    localparam logic [2:0] STOP_PIPE  = 3'd2;
    localparam logic [2:0] STOP_IN    = 3'd3;
    localparam logic [2:0] STOP_OUT   = 3'd4;

    // Result queue sizing
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_AW    = 2;
    localparam int unsigned FIFO_CW    = 3;

    typedef struct packed {
        logic [7:0] out_char;
        logic       has_char;
        logic       word_end;
        logic [2:0] stop_reason;
        logic       drop_last;
        logic       stderr_redirect;
        logic       quote_open;
        logic       last;
    } res_t;

    // Up to two results caused by one character
    typedef struct packed {
        res_t       r0;
        res_t       r1;
        logic [1:0] n;
    } dec_t;

    function automatic res_t mk_char(input logic [7:0] c);
        res_t r;
        r          = '0;
        r.out_char = c;
        r.has_char = 1'b1;
        return r;
    endfunction

    function automatic res_t mk_end(input logic [2:0] reason, input logic drop,
                                    input logic err, input logic qopen);
        res_t r;
        r                 = '0;
        r.word_end        = 1'b1;
        r.stop_reason     = reason;
        r.drop_last       = drop;
        r.stderr_redirect = err;
        r.quote_open      = qopen;
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/shell_word_tokenizer.sv
`default_nettype none

// Shell word tokenizer: takes one command-line character per word on the s_
// side and streams the characters of shell words on the m_ side, honoring
// single quotes, double quotes and backslash escapes. An unquoted space, pipe,
// '<', '>' or a zero byte ends the word with a reason code; before '>' a digit
// just emitted is flagged for removal, and a '2' marks a stderr redirect.
// A character is taken every cycle while the result side keeps up; the
// m_ side delivers one result per cycle while m_tready is high, and a
// backslash pair inside double quotes gives two results. A character is
// held in the input register, then its results in the four-entry result
// queue, which admits a character only while two or more slots are free.

module shell_word_tokenizer (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] ch
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [7:0] out_char, [10:8] stop_reason,
                                        // [11] drop_last, [12] stderr_redirect,
                                        // [13] quote_open, [15:14] zero
    output logic [1:0]       m_tuser,   // [0] has_char, [1] word_end
    output logic             m_tlast
);
    import swt_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_ch_reg;
    logic       room;
    logic       advance;
    dec_t       dec;
    res_t       res;

    assign advance  = in_valid_reg && room;
    assign s_tready = !in_valid_reg || advance;

    // Hold the incoming character
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_ch_reg <= s_tdata;
        end
    end

    swt_decode u_decode (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .ch      (in_ch_reg),
        .dec     (dec)
    );

    swt_res_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (advance),
        .dec     (dec),
        .room    (room),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_res   (res)
    );

    // Pack the result word
    assign m_tdata = {2'b00, res.quote_open, res.stderr_redirect, res.drop_last,
                      res.stop_reason, res.out_char};
    assign m_tuser = {res.word_end, res.has_char};
    assign m_tlast = res.last;

endmodule

`default_nettype wire

// File: rtl/core/swt_decode.sv
`default_nettype none

module swt_decode (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          advance,
    input  wire logic [7:0]    ch,
    output swt_pkg::dec_t      dec
);
    import swt_pkg::*;

    logic       sq_reg, sq_next;
    logic       dq_reg, dq_next;
    logic       esc_reg, esc_next;
    logic [7:0] prev_reg;
    logic       prev_digit;
    logic       keep_bs;

    assign prev_digit = (prev_reg >= CH_ZERO) && (prev_reg <= CH_NINE);
    assign keep_bs    = (ch != CH_BSLASH) && (ch != CH_DQUOTE) &&
                        (ch != CH_DOLLAR) && (ch != CH_NEWLINE);

    // Decode one character against the quoting state
    always_comb begin
        dec      = '0;
        sq_next  = sq_reg;
        dq_next  = dq_reg;
        esc_next = esc_reg;
        priority if (ch == CH_NUL) begin
            dec.r0   = mk_end(STOP_END, 1'b0, 1'b0, sq_reg | dq_reg);
            dec.n    = 2'd1;
            sq_next  = 1'b0;
            dq_next  = 1'b0;
            esc_next = 1'b0;
        end else if (esc_reg) begin
            esc_next = 1'b0;
            if (dq_reg && keep_bs) begin
                dec.r0 = mk_char(CH_BSLASH);
                dec.r1 = mk_char(ch);
                dec.n  = 2'd2;
            end else begin
                dec.r0 = mk_char(ch);
                dec.n  = 2'd1;
            end
        end else if (sq_reg) begin
            if (ch == CH_SQUOTE) begin
                sq_next = 1'b0;
            end else begin
                dec.r0 = mk_char(ch);
                dec.n  = 2'd1;
            end
        end else if (dq_reg) begin
            if (ch == CH_DQUOTE) begin
                dq_next = 1'b0;
            end else if (ch == CH_BSLASH) begin
                esc_next = 1'b1;
            end else begin
                dec.r0 = mk_char(ch);
                dec.n  = 2'd1;
            end
        end else begin
            unique case (ch)
                CH_DQUOTE: dq_next  = 1'b1;
                CH_SQUOTE: sq_next  = 1'b1;
                CH_BSLASH: esc_next = 1'b1;
                CH_SPACE, CH_PIPE, CH_LT: begin
                    dec.n = 2'd1;
                    if (ch == CH_SPACE) begin
                        dec.r0 = mk_end(STOP_SPACE, 1'b0, 1'b0, 1'b0);
                    end else if (ch == CH_PIPE) begin
                        dec.r0 = mk_end(STOP_PIPE, 1'b0, 1'b0, 1'b0);
                    end else begin
                        dec.r0 = mk_end(STOP_IN, 1'b0, 1'b0, 1'b0);
                    end
                    sq_next  = 1'b0;
                    dq_next  = 1'b0;
                    esc_next = 1'b0;
                end
                CH_GT: begin
                    dec.r0   = mk_end(STOP_OUT, prev_digit,
                                      prev_digit && (prev_reg == CH_TWO), 1'b0);
                    dec.n    = 2'd1;
                    sq_next  = 1'b0;
                    dq_next  = 1'b0;
                    esc_next = 1'b0;
                end
                default: begin
                    dec.r0 = mk_char(ch);
                    dec.n  = 2'd1;
                end
            endcase
        end
        // Mark the final result of this character
        if (dec.n == 2'd1) begin
            dec.r0.last = 1'b1;
        end
        if (dec.n == 2'd2) begin
            dec.r1.last = 1'b1;
        end
    end

    // Advance the quoting state once per character
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_reg   <= 1'b0;
            dq_reg   <= 1'b0;
            esc_reg  <= 1'b0;
            prev_reg <= CH_SPACE;
        end else if (advance) begin
            sq_reg   <= sq_next;
            dq_reg   <= dq_next;
            esc_reg  <= esc_next;
            prev_reg <= ch;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/swt_res_fifo.sv
`default_nettype none

module swt_res_fifo (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  swt_pkg::dec_t      dec,
    output logic               room,
    output logic               m_valid,
    input  wire logic          m_ready,
    output swt_pkg::res_t      m_res
);
    import swt_pkg::*;

    res_t                mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]  wp_reg, wp_next;
    logic [FIFO_AW-1:0]  rp_reg, rp_next;
    logic [FIFO_CW-1:0]  cnt_reg, cnt_next;
    logic [1:0]          push_n;
    logic                pop;

    assign push_n  = push ? dec.n : 2'd0;
    assign m_valid = (cnt_reg != '0);
    assign pop     = m_valid && m_ready;
    assign m_res   = mem[rp_reg];
    // Take a character only when two free slots are certain
    assign room    = (cnt_reg <= FIFO_CW'(FIFO_DEPTH - 2));

    // Advance pointers and fill count
    always_comb begin
        wp_next  = wp_reg + FIFO_AW'(push_n);
        rp_next  = rp_reg + FIFO_AW'(pop);
        cnt_next = cnt_reg + FIFO_CW'(push_n) - FIFO_CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    // Write up to two results per cycle
    always_ff @(posedge aclk) begin
        if (push_n != 2'd0) begin
            mem[wp_reg] <= dec.r0;
        end
        if (push_n == 2'd2) begin
            mem[wp_reg + FIFO_AW'(1)] <= dec.r1;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/swt_checker.sv
`default_nettype none

`include "assert_macros.svh"

module swt_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic [1:0]  m_tuser,
    input wire logic        m_tlast
);
    import swt_pkg::*;

    // A result is either a character or a word end, never both or neither
    `ASSERT_CLK(a_kind_onehot, aclk, aresetn, m_tvalid |-> $onehot(m_tuser), "result kind broken")

    // A word end carries no character and ends the results of its word
    `ASSERT_CLK(a_end_clean, aclk, aresetn, (m_tvalid && m_tuser[1]) |-> ((m_tdata[7:0] == 8'h00) && m_tlast), "word end carries data")

    // Descriptor flags only on an output redirect, stderr only with a dropped digit
    `ASSERT_CLK(a_redir_flags, aclk, aresetn, (m_tvalid && (m_tdata[11] || m_tdata[12])) |-> ((m_tdata[10:8] == STOP_OUT) && m_tdata[11]), "redirect flags misplaced")

    // A stalled result is held until taken
    `ASSERT_CLK(a_hold, aclk, aresetn, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast)), "stalled result changed")

    // No output traffic while reset is asserted
    `ASSERT_ALWAYS(a_reset_quiet, aclk, !aresetn |=> (!m_tvalid || !$past(aresetn) == 1'b0), "output valid after reset")

endmodule

bind shell_word_tokenizer swt_checker u_swt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

// File: tb/shell_word_tokenizer_checker.sv
`timescale 1ns / 100ps

// Watches both channels of the tokenizer, predicts the words each accepted
// character should produce and compares them in order with what comes out.
module shell_word_tokenizer_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] ch
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,    // [7:0] out_char, [10:8] stop_reason,
                                    // [11] drop_last, [12] stderr_redirect,
                                    // [13] quote_open, [15:14] zero
    input  logic [1:0]  m_tuser,    // [0] has_char, [1] word_end
    input  logic        m_tlast,
    output int          fail_count,
    output int          results_pending,
    output int          results_checked,
    output int          chars_with_results
);
    import swt_pkg::*;

    localparam int MAX_PRINTED = 40;

    // Tokenizer state as the predictor sees it
    logic       in_sq;
    logic       in_dq;
    logic       esc_pending;
    logic [7:0] prev_ch;

    res_t pending_words[$];
    int   mismatches;
    int   checked;
    int   productive_chars;

    initial begin
        fail_count         = 0;
        results_pending    = 0;
        results_checked    = 0;
        chars_with_results = 0;
        mismatches         = 0;
        checked            = 0;
        productive_chars   = 0;
        in_sq              = 1'b0;
        in_dq              = 1'b0;
        esc_pending        = 1'b0;
        prev_ch            = CH_SPACE;
    end

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        if (mismatches < MAX_PRINTED)
            $display("%0t ns: word %0d: %s got 0x%0h, want 0x%0h",
                     $time, checked, what, got, want);
        mismatches++;
    endtask

    function automatic res_t word_char(input logic [7:0] c);
        return '{out_char: c, has_char: 1'b1, default: '0};
    endfunction

    function automatic res_t word_stop(input logic [2:0] why, input logic drop,
                                       input logic err, input logic qopen);
        return '{word_end: 1'b1, stop_reason: why, drop_last: drop,
                 stderr_redirect: err, quote_open: qopen, default: '0};
    endfunction

    // Work out the words caused by one character and queue them
    task automatic tokenize_char(input logic [7:0] c);
        res_t       words[$];
        logic [7:0] p;
        logic       fd_digit;
        logic       ends_word;
        p         = prev_ch;
        prev_ch   = c;
        ends_word = 1'b0;
        fd_digit  = (p >= CH_ZERO) && (p <= CH_NINE);

        if (c == CH_NUL) begin
            words.push_back(word_stop(STOP_END, 1'b0, 1'b0, in_sq | in_dq));
            ends_word = 1'b1;
        end else if (esc_pending) begin
            esc_pending = 1'b0;
            // inside double quotes the backslash survives unless it escapes
            // one of the four special characters
            if (in_dq && !(c inside {CH_BSLASH, CH_DQUOTE, CH_DOLLAR, CH_NEWLINE}))
                words.push_back(word_char(CH_BSLASH));
            words.push_back(word_char(c));
        end else if (in_sq) begin
            if (c == CH_SQUOTE)
                in_sq = 1'b0;
            else
                words.push_back(word_char(c));
        end else if (in_dq) begin
            if (c == CH_DQUOTE)
                in_dq = 1'b0;
            else if (c == CH_BSLASH)
                esc_pending = 1'b1;
            else
                words.push_back(word_char(c));
        end else begin
            case (c)
                CH_DQUOTE: in_dq = 1'b1;
                CH_SQUOTE: in_sq = 1'b1;
                CH_BSLASH: esc_pending = 1'b1;
                CH_SPACE: begin
                    words.push_back(word_stop(STOP_SPACE, 1'b0, 1'b0, 1'b0));
                    ends_word = 1'b1;
                end
                CH_PIPE: begin
                    words.push_back(word_stop(STOP_PIPE, 1'b0, 1'b0, 1'b0));
                    ends_word = 1'b1;
                end
                CH_LT: begin
                    words.push_back(word_stop(STOP_IN, 1'b0, 1'b0, 1'b0));
                    ends_word = 1'b1;
                end
                CH_GT: begin
                    words.push_back(word_stop(STOP_OUT, fd_digit,
                                              fd_digit && (p == CH_TWO), 1'b0));
                    ends_word = 1'b1;
                end
                default: words.push_back(word_char(c));
            endcase
        end

        // a finished word drops any quoting in force
        if (ends_word) begin
            in_sq       = 1'b0;
            in_dq       = 1'b0;
            esc_pending = 1'b0;
        end

        if (words.size() > 0) begin
            words[words.size() - 1].last = 1'b1;
            productive_chars++;
        end
        foreach (words[i])
            pending_words.push_back(words[i]);
    endtask

    // Compare one delivered word with the oldest prediction
    task automatic check_word();
        res_t got;
        res_t want;
        got.out_char        = m_tdata[7:0];
        got.stop_reason     = m_tdata[10:8];
        got.drop_last       = m_tdata[11];
        got.stderr_redirect = m_tdata[12];
        got.quote_open      = m_tdata[13];
        got.has_char        = m_tuser[0];
        got.word_end        = m_tuser[1];
        got.last            = m_tlast;

        if (pending_words.size() == 0) begin
            report_mismatch("unexpected word, out_char", got.out_char, 8'h00);
        end else begin
            want = pending_words.pop_front();
            if (got.out_char !== want.out_char)
                report_mismatch("out_char", got.out_char, want.out_char);
            if (got.has_char !== want.has_char)
                report_mismatch("has_char", 8'(got.has_char), 8'(want.has_char));
            if (got.word_end !== want.word_end)
                report_mismatch("word_end", 8'(got.word_end), 8'(want.word_end));
            if (got.stop_reason !== want.stop_reason)
                report_mismatch("stop_reason", 8'(got.stop_reason),
                                8'(want.stop_reason));
            if (got.drop_last !== want.drop_last)
                report_mismatch("drop_last", 8'(got.drop_last), 8'(want.drop_last));
            if (got.stderr_redirect !== want.stderr_redirect)
                report_mismatch("stderr_redirect", 8'(got.stderr_redirect),
                                8'(want.stderr_redirect));
            if (got.quote_open !== want.quote_open)
                report_mismatch("quote_open", 8'(got.quote_open),
                                8'(want.quote_open));
            if (got.last !== want.last)
                report_mismatch("last", 8'(got.last), 8'(want.last));
        end
        checked++;
    endtask

    // Check outputs first: nothing accepted at this edge can already be out
    always @(posedge aclk) begin
        if (!aresetn) begin
            in_sq       = 1'b0;
            in_dq       = 1'b0;
            esc_pending = 1'b0;
            prev_ch     = CH_SPACE;
            pending_words.delete();
        end else begin
            if (m_tvalid === 1'b1 && m_tready)
                check_word();
            if (s_tvalid && s_tready === 1'b1)
                tokenize_char(s_tdata);
        end
        fail_count         <= mismatches;
        results_pending    <= pending_words.size();
        results_checked    <= checked;
        chars_with_results <= productive_chars;
    end

endmodule

// File: tb/shell_word_tokenizer_tb.sv
`timescale 1ns / 100ps

module shell_word_tokenizer_tb;
    import swt_pkg::*;

    localparam int LONG_HOLD    = 64;
    localparam int DRAIN_LIMIT  = 2000;
    localparam int TARGET_CHARS = 850;

    // Short hand-picked command line: extremes, every stop reason,
    // fd digits before '>', escapes and quotes left open at the end
    localparam logic [7:0] DIRECTED_LINE [0:25] = '{
        8'hFF, "a", CH_SPACE, CH_TWO, CH_GT, "7", CH_GT, "x", CH_GT,
        CH_PIPE, CH_LT, CH_SQUOTE, CH_SPACE, CH_SQUOTE, CH_DQUOTE, CH_BSLASH,
        "n", CH_BSLASH, CH_DOLLAR, CH_DQUOTE, CH_BSLASH, CH_PIPE, CH_DQUOTE,
        CH_NUL, CH_BSLASH, CH_NUL
    };

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;    // [7:0] ch
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;          // [7:0] out_char, [10:8] stop_reason,
                                   // [11] drop_last, [12] stderr_redirect,
                                   // [13] quote_open, [15:14] zero
    logic [1:0]  m_tuser;          // [0] has_char, [1] word_end
    logic        m_tlast;

    int   fail_count;
    int   results_pending;
    int   results_checked;
    int   chars_with_results;
    int   chars_sent   = 0;
    bit   tx_idle_on   = 1'b0;
    logic rx_idle_on   = 1'b0;
    logic rx_long_req  = 1'b0;
    int   rx_hold      = 0;
    int   drain_cycles;

    shell_word_tokenizer u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    shell_word_tokenizer_checker u_checker (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_tvalid           (s_tvalid),
        .s_tready           (s_tready),
        .s_tdata            (s_tdata),
        .m_tvalid           (m_tvalid),
        .m_tready           (m_tready),
        .m_tdata            (m_tdata),
        .m_tuser            (m_tuser),
        .m_tlast            (m_tlast),
        .fail_count         (fail_count),
        .results_pending    (results_pending),
        .results_checked    (results_checked),
        .chars_with_results (chars_with_results)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // Receiver: random stall bursts, or one long hold-off on request
    always @(posedge aclk) begin
        if (rx_long_req) begin
            rx_long_req <= 1'b0;
            rx_hold = LONG_HOLD;
        end else if (rx_hold == 0 && rx_idle_on && $urandom_range(0, 5) == 0) begin
            rx_hold = $urandom_range(1, 4);
        end
        if (rx_hold > 0) begin
            m_tready <= 1'b0;
            rx_hold--;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Offer one character and hold it until it is taken
    task automatic send_char(input logic [7:0] c);
        if (tx_idle_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tdata  <= c;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (s_tready !== 1'b1);
        chars_sent++;
    endtask

    // Stop offering until every predicted word has come out
    task automatic pause_until_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_pending != 0) @(posedge aclk);
    endtask

    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        do c = 8'($urandom_range(8'h21, 8'h7E));
        while (c inside {CH_DQUOTE, CH_SQUOTE, CH_BSLASH, CH_PIPE, CH_LT, CH_GT});
        return c;
    endfunction

    function automatic logic [7:0] escaped_char();
        case ($urandom_range(0, 4))
            0: return CH_BSLASH;
            1: return CH_DQUOTE;
            2: return CH_DOLLAR;
            3: return CH_NEWLINE;
            default: return 8'($urandom_range(1, 255));
        endcase
    endfunction

    // One random command line: words, quoted runs, escapes, separators and
    // redirects, with some raw noise, closed by the end-of-string mark
    task automatic send_command();
        logic [7:0] c;
        repeat ($urandom_range(1, 8)) begin
            case ($urandom_range(0, 9))
                0, 1, 2: repeat ($urandom_range(1, 5)) send_char(plain_char());
                3: begin
                    send_char(CH_SQUOTE);
                    repeat ($urandom_range(0, 4)) begin
                        do c = 8'($urandom_range(1, 255)); while (c == CH_SQUOTE);
                        send_char(c);
                    end
                    send_char(CH_SQUOTE);
                end
                4: begin
                    send_char(CH_DQUOTE);
                    repeat ($urandom_range(0, 4)) begin
                        if ($urandom_range(0, 2) == 0) begin
                            send_char(CH_BSLASH);
                            send_char(escaped_char());
                        end else begin
                            do c = 8'($urandom_range(1, 255));
                            while (c == CH_DQUOTE || c == CH_BSLASH);
                            send_char(c);
                        end
                    end
                    send_char(CH_DQUOTE);
                end
                5: begin
                    send_char(CH_BSLASH);
                    send_char(8'($urandom_range(1, 255)));
                end
                6: begin
                    case ($urandom_range(0, 3))
                        0: send_char(CH_SPACE);
                        1: send_char(CH_PIPE);
                        2: send_char(CH_LT);
                        default: send_char(CH_GT);
                    endcase
                end
                7: begin
                    if ($urandom_range(0, 1) == 0)
                        send_char(CH_TWO);
                    else
                        send_char(CH_ZERO + 8'($urandom_range(0, 9)));
                    send_char(CH_GT);
                end
                8: send_char(8'($urandom_range(0, 255)));
                default: send_char(CH_SPACE);
            endcase
        end
        // mostly end cleanly; sometimes leave a quote or an escape open
        case ($urandom_range(0, 7))
            0: send_char(CH_SQUOTE);
            1: send_char(CH_DQUOTE);
            2: send_char(CH_BSLASH);
            default: ;
        endcase
        send_char(CH_NUL);
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed line, no idling on either side
        foreach (DIRECTED_LINE[i])
            send_char(DIRECTED_LINE[i]);
        pause_until_drained();

        tx_idle_on = 1'b1;
        rx_idle_on <= 1'b1;
        while (chars_sent < 300)
            send_command();

        // hold the result side off while characters keep coming
        rx_long_req <= 1'b1;
        repeat (30) send_char(plain_char());
        send_char(CH_NUL);
        pause_until_drained();

        while (chars_sent < 700)
            send_command();
        pause_until_drained();

        // final stretch at full rate
        tx_idle_on = 1'b0;
        rx_idle_on <= 1'b0;
        while (chars_sent < TARGET_CHARS)
            send_command();
        s_tvalid <= 1'b0;

        drain_cycles = 0;
        while (results_pending != 0 && drain_cycles < DRAIN_LIMIT) begin
            @(posedge aclk);
            drain_cycles++;
        end
        repeat (8) @(posedge aclk);

        $display("Sent %0d characters (%0d with output), checked %0d words: plain,",
                 chars_sent, chars_with_results, results_checked);
        $display("quoted and escaped text, every stop reason, fd digits before '>'");
        $display("and a %0d-cycle output hold-off", LONG_HOLD);
        if (fail_count == 0 && results_pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Timeout with %0d words outstanding", results_pending);
        $display("Some tests failed");
        $finish;
    end

endmodule
